// File: hdl/res_pkg.sv
`default_nettype none
package res_pkg;

    localparam int unsigned KEY_W   = 12;
    localparam int unsigned SCORE_W = 42;
    localparam int unsigned INFO_W  = 35;

    typedef logic [SCORE_W-1:0] t_score_word;
    typedef logic [INFO_W-1:0]  t_info_word;
    typedef logic [KEY_W-1:0]   t_key;

    typedef struct packed {
        logic [11:0] total_score;
        logic [9:0]  c_score;
        logic [9:0]  math_score;
        logic [9:0]  english_score;
        logic [11:0] birth_year;
        logic [6:0]  age;
        logic [15:0] record_tag;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [11:0] sorted_total;
        logic [9:0]  sorted_c;
        logic [9:0]  sorted_math;
        logic [9:0]  sorted_english;
        logic [11:0] sorted_birth;
        logic [6:0]  sorted_age;
        logic [15:0] sorted_tag;
        logic        final_res;
        logic        overflow;
    } t_out_item;

    function automatic t_score_word pack_score(input t_in_item item);
        return {item.english_score, item.math_score, item.c_score, item.total_score};
    endfunction

    function automatic t_info_word pack_info(input t_in_item item);
        return {item.record_tag, item.age, item.birth_year};
    endfunction

    function automatic t_key key_of(input t_score_word word);
        return word[KEY_W-1:0];
    endfunction

    function automatic t_out_item make_out(input t_score_word score, input t_info_word info,
                                           input logic fin, input logic ovf);
        t_out_item item;
        item.sorted_total   = score[11:0];
        item.sorted_c       = score[21:12];
        item.sorted_math    = score[31:22];
        item.sorted_english = score[41:32];
        item.sorted_birth   = info[11:0];
        item.sorted_age     = info[18:12];
        item.sorted_tag     = info[34:19];
        item.final_res      = fin;
        item.overflow       = ovf;
        return item;
    endfunction

endpackage
`default_nettype wire

// File: hdl/res_if.sv
`default_nettype none
interface res_in_if;
    import res_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface res_out_if;
    import res_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/res_ram.sv
`default_nettype none
module res_ram #(
    parameter int unsigned WIDTH = 42,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/record_exchange_sort.sv
`default_nettype none
// record exchange sort
// i_in carries one record per item; the item with last set closes the set.
// o_out returns the set in ascending order of total score once it is sorted,
// final_res on the last record and overflow on every record when records
// beyond MAX_RECORDS were dropped from the set.
// loading takes an item on every valid; i_in is ready only while loading.
// sorting scans the set once per outer position, one compare per cycle
// against the record held for the current outer position, paced by the
// single read port of the record memories.
// emitting captures each record only once the one before has been taken.
// a stalled o_out holds its record and valid until taken; nothing else moves.
// the first item of the next set is taken the cycle after the final record.
// synchronous reset empties the set and clears the output valid; the memory
// contents are left as they are and only entries of the current set are used.
module record_exchange_sort #(
    parameter int unsigned MAX_RECORDS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    res_in_if.sink     i_in,
    res_out_if.source  o_out
);
    import res_pkg::*;

    localparam int unsigned AW = $clog2(MAX_RECORDS);
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_RD_I   = 3'd1;
    localparam logic [2:0] S_CUR    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_WB     = 3'd4;
    localparam logic [2:0] S_E_RD   = 3'd5;
    localparam logic [2:0] S_E_CAP  = 3'd6;
    localparam logic [2:0] S_E_WAIT = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    t_score_word   r_cur_score, n_cur_score;
    t_info_word    r_cur_info, n_cur_info;
    t_out_item     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_score_word   wscore, rd_score;
    t_info_word    winfo, rd_info;
    logic          in_fire;
    logic          full;
    logic [CW-1:0] last_idx;

    res_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_RECORDS)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wscore),
        .i_raddr (raddr),
        .o_rdata (rd_score)
    );

    res_ram #(.WIDTH(INFO_W), .DEPTH(MAX_RECORDS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (winfo),
        .i_raddr (raddr),
        .o_rdata (rd_info)
    );

    assign i_in.ready    = (r_state == S_LOAD);
    assign in_fire       = i_in.valid && (r_state == S_LOAD);
    assign full          = (r_count == CW'(MAX_RECORDS));
    assign last_idx      = r_count - CW'(1);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_cur_score = r_cur_score;
        n_cur_info  = r_cur_info;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        we          = 1'b0;
        waddr       = r_j;
        wscore      = r_cur_score;
        winfo       = r_cur_info;
        raddr       = r_i;
        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (!full) begin
                        we      = 1'b1;
                        waddr   = r_count[AW-1:0];
                        wscore  = pack_score(i_in.payload);
                        winfo   = pack_info(i_in.payload);
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in.payload.last) begin
                        n_i = '0;
                        n_k = '0;
                        if (n_count >= CW'(2)) begin
                            n_state = S_RD_I;
                        end else if (n_count == CW'(1)) begin
                            n_state = S_E_RD;
                        end else begin
                            n_count   = '0;
                            n_dropped = 1'b0;
                        end
                    end
                end
            end
            S_RD_I: begin
                raddr   = r_i;
                n_state = S_CUR;
            end
            S_CUR: begin
                n_cur_score = rd_score;
                n_cur_info  = rd_info;
                raddr       = r_i + AW'(1);
                n_j         = r_i + AW'(1);
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                raddr = r_j + AW'(1);
                n_j   = r_j + AW'(1);
                // held record moves down to j, the smaller one takes its place
                if (key_of(r_cur_score) > key_of(rd_score)) begin
                    we          = 1'b1;
                    waddr       = r_j;
                    n_cur_score = rd_score;
                    n_cur_info  = rd_info;
                end
                if (CW'(r_j) == last_idx) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                we    = 1'b1;
                waddr = r_i;
                raddr = r_i + AW'(1);
                n_i   = r_i + AW'(1);
                if (CW'(r_i) + CW'(1) == last_idx) begin
                    n_k     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_state = S_CUR;
                end
            end
            S_E_RD: begin
                raddr   = r_k;
                n_state = S_E_CAP;
            end
            S_E_CAP: begin
                n_out       = make_out(rd_score, rd_info, CW'(r_k) == last_idx, r_dropped);
                n_out_valid = 1'b1;
                n_state     = S_E_WAIT;
            end
            S_E_WAIT: begin
                raddr = r_k + AW'(1);
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.final_res) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_E_CAP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_cur_score <= n_cur_score;
        r_cur_info  <= n_cur_info;
        r_out       <= n_out;
    end

endmodule
`default_nettype wire

// File: hdl/res_checker.sv
`default_nettype none
module res_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire res_pkg::t_out_item   i_out_payload
);
    import res_pkg::*;

    // a stalled item stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item withdrawn while stalled");

    a_out_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_payload))
        else $error("output item changed while stalled");

    // no loading while a sorted set is being returned
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while an output item is pending");

    // the next set may start right after the final record
    a_ready_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_payload.final_res |=> i_in_ready && !i_out_valid)
        else $error("block not ready for a new set after the final record");

endmodule

bind record_exchange_sort res_checker u_res_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
`default_nettype wire

// File: dv/record_exchange_sort_test.sv
module record_exchange_sort_test;
    import res_pkg::*;

    localparam int unsigned CAPACITY      = 64;
    localparam int unsigned RANDOM_ITEMS  = 24;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned RUN_LIMIT     = 400000;

    logic i_clk;
    logic i_rst_n;

    res_in_if  in_ch ();
    res_out_if out_ch ();

    record_exchange_sort #(
        .MAX_RECORDS (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // records of the set being loaded, and the sorted records still owed
    t_in_item    set_records [$];
    bit          set_dropped = 1'b0;
    t_out_item   sorted_due [$];
    int unsigned mismatch_count = 0;
    bit          gaps_on = 1'b1;
    bit          hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // exchange sort of the finished set, then queue the records in emit order
    function automatic void sort_and_queue();
        t_in_item  held [$];
        t_in_item  swap_rec;
        t_out_item due;
        int        n;
        held = set_records;
        n = held.size();
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (held[i].total_score > held[j].total_score) begin
                    swap_rec = held[i];
                    held[i]  = held[j];
                    held[j]  = swap_rec;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            due.sorted_total   = held[k].total_score;
            due.sorted_c       = held[k].c_score;
            due.sorted_math    = held[k].math_score;
            due.sorted_english = held[k].english_score;
            due.sorted_birth   = held[k].birth_year;
            due.sorted_age     = held[k].age;
            due.sorted_tag     = held[k].record_tag;
            due.final_res      = (k == n - 1);
            due.overflow       = set_dropped;
            sorted_due.push_back(due);
        end
    endfunction

    function automatic void absorb_record(input t_in_item rec);
        if (set_records.size() < CAPACITY) begin
            set_records.push_back(rec);
        end else begin
            set_dropped = 1'b1;
        end
        if (rec.last) begin
            sort_and_queue();
            set_records.delete();
            set_dropped = 1'b0;
        end
    endfunction

    task automatic compare_field(input string label, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_sorted(input t_out_item got);
        t_out_item want;
        if (sorted_due.size() == 0) begin
            $display("%0t: unexpected record, expected none actual total %0d tag %0d",
                     $time, got.sorted_total, got.sorted_tag);
            mismatch_count++;
        end else begin
            want = sorted_due.pop_front();
            compare_field("sorted_total", 32'(want.sorted_total), 32'(got.sorted_total));
            compare_field("sorted_c", 32'(want.sorted_c), 32'(got.sorted_c));
            compare_field("sorted_math", 32'(want.sorted_math), 32'(got.sorted_math));
            compare_field("sorted_english", 32'(want.sorted_english),
                          32'(got.sorted_english));
            compare_field("sorted_birth", 32'(want.sorted_birth), 32'(got.sorted_birth));
            compare_field("sorted_age", 32'(want.sorted_age), 32'(got.sorted_age));
            compare_field("sorted_tag", 32'(want.sorted_tag), 32'(got.sorted_tag));
            compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
            compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
        end
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                check_sorted(out_ch.payload);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** record_exchange_sort: FAILED **");
        $finish;
    end

    function automatic t_in_item make_record(input int unsigned key, input bit last_flag);
        t_in_item rec;
        rec.total_score   = 12'(key);
        rec.c_score       = 10'($urandom_range(0, 1000));
        rec.math_score    = 10'($urandom_range(0, 1000));
        rec.english_score = 10'($urandom_range(0, 1000));
        rec.birth_year    = 12'($urandom_range(0, 4095));
        rec.age           = 7'($urandom_range(0, 127));
        rec.record_tag    = 16'($urandom_range(0, 65535));
        rec.last          = last_flag;
        return rec;
    endfunction

    // valid stays up after the handshake; the next item or drain_sorted takes it down
    task automatic send_record(input t_in_item rec);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= rec;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        absorb_record(rec);
    endtask

    task automatic send_keys(input int unsigned keys [$]);
        for (int k = 0; k < keys.size(); k++) begin
            send_record(make_record(keys[k], k == keys.size() - 1));
        end
    endtask

    task automatic send_set(input int unsigned size, input int unsigned key_top);
        for (int unsigned k = 0; k < size; k++) begin
            send_record(make_record($urandom_range(0, key_top), k == size - 1));
        end
    endtask

    task automatic drain_sorted();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_records();
        t_in_item rec;
        rec = make_record(3000, 1'b1);
        rec.c_score       = 10'd1000;
        rec.math_score    = 10'd1000;
        rec.english_score = 10'd1000;
        rec.birth_year    = 12'd4095;
        rec.age           = 7'd127;
        rec.record_tag    = 16'hFFFF;
        send_record(rec);
        rec = '0;
        rec.last = 1'b1;
        send_record(rec);
        drain_sorted();
    endtask

    task automatic test_small_orders();
        send_keys('{3000, 0});
        send_keys('{12, 12});
        send_keys('{7, 3, 7, 3, 0});
        send_keys('{6, 5, 4, 3, 2, 1});
        send_keys('{0, 1, 2, 2, 3000});
        drain_sorted();
    endtask

    // a set that exactly fills the store, then one whose tail, last item too, is dropped
    task automatic test_capacity();
        send_set(CAPACITY, 3000);
        send_set(CAPACITY + 3, 3000);
        drain_sorted();
    endtask

    task automatic test_random_sets();
        int unsigned sent;
        int unsigned size;
        int unsigned key_top;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                size = $urandom_range(CAPACITY - 4, CAPACITY + 4);
            end else begin
                size = $urandom_range(1, 12);
            end
            key_top = $urandom_range(0, 1) ? 3000 : $urandom_range(0, 15);
            send_set(size, key_top);
            sent += size;
        end
        gaps_on = 1'b1;
        drain_sorted();
    endtask

    // output held off while further sets keep arriving
    task automatic test_output_hold();
        hold_request = 1'b1;
        send_set(8, 3000);
        send_set(10, 7);
        send_set(6, 3000);
        drain_sorted();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        send_set(7, 3000);
        send_set(1, 3000);
        send_set(12, 3);
        drain_sorted();
    endtask

    initial begin : run
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        i_rst_n       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_records();
        test_small_orders();
        test_capacity();
        test_random_sets();
        test_output_hold();
        test_back_to_back();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && sorted_due.size() == 0) begin
            $display("** record_exchange_sort: PASSED **");
        end else begin
            $display("** record_exchange_sort: FAILED **");
        end
        $finish;
    end

endmodule
